/* rtl/core/smrk_pkg.sv */
// Shared types, constants and arithmetic helpers for the sort/merge reduce-by-key block.
package smrk_pkg;

    localparam int KEY_W        = 64;
    localparam int AMP_W        = 32;
    localparam int FLAG_W       = 2;
    localparam int TOT_W        = 40;
    localparam int REPLICAS     = 2;
    localparam int CAPACITY_DEF = 64;

    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 280;
    localparam int CFG_DATA_W = 2;

    // output tdata bit offsets
    localparam int O_KH  = 0;
    localparam int O_KL  = 64;
    localparam int O_A0  = 128;
    localparam int O_A1  = 160;
    localparam int O_FL  = 192;
    localparam int O_T0  = 194;
    localparam int O_T1  = 234;
    localparam int O_OVF = 274;

    // configuration register indexes
    localparam logic CFG_REPLICAS  = 1'b0;
    localparam logic CFG_INIT_MODE = 1'b1;

    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    typedef struct packed {
        logic [KEY_W-1:0]        key_high;
        logic [KEY_W-1:0]        key_low;
        logic signed [AMP_W-1:0] amp_first;
        logic signed [AMP_W-1:0] amp_second;
        logic [FLAG_W-1:0]       init_flags;
        logic                    last;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_head_t;

    function automatic logic signed [AMP_W-1:0] sat_add(
        input logic signed [AMP_W-1:0] a,
        input logic signed [AMP_W-1:0] b
    );
        logic signed [AMP_W:0] s;
        s = {a[AMP_W-1], a} + {b[AMP_W-1], b};
        if (s[AMP_W] != s[AMP_W-1])
            return s[AMP_W] ? {1'b1, {(AMP_W-1){1'b0}}} : {1'b0, {(AMP_W-1){1'b1}}};
        return s[AMP_W-1:0];
    endfunction

    // opposite signs: add twice the smaller magnitude, clamp at all ones
    function automatic logic [TOT_W-1:0] annihilate(
        input logic [TOT_W-1:0]        total,
        input logic signed [AMP_W-1:0] acc,
        input logic signed [AMP_W-1:0] x
    );
        logic [AMP_W:0] ma;
        logic [AMP_W:0] mx;
        logic [AMP_W:0] m;
        logic [TOT_W:0] s;
        logic           opp;
        ma  = acc[AMP_W-1] ? (~{1'b1, acc} + 1'b1) : {1'b0, acc};
        mx  = x[AMP_W-1] ? (~{1'b1, x} + 1'b1) : {1'b0, x};
        m   = (ma < mx) ? ma : mx;
        opp = (acc[AMP_W-1] && !x[AMP_W-1] && (x != '0))
            || (x[AMP_W-1] && !acc[AMP_W-1] && (acc != '0));
        s   = {1'b0, total} + {{(TOT_W-AMP_W-1){1'b0}}, m, 1'b0};
        if (!opp)
            return total;
        return s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
    endfunction

endpackage

/* rtl/core/smrk_front.sv */
// Input side: unpacks stream transactions into a two-entry queue for the back end.
module smrk_front
    import smrk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_tvalid,
    output logic                 in_tready,
    input  logic [IN_DATA_W-1:0] in_tdata,
    input  logic                 in_tlast,
    output queue_head_t          head,
    input  logic                 pop
);

    entry_t     q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       do_pop;
    entry_t     in_entry;

    assign in_entry.key_high   = in_tdata[63:0];
    assign in_entry.key_low    = in_tdata[127:64];
    assign in_entry.amp_first  = in_tdata[159:128];
    assign in_entry.amp_second = in_tdata[191:160];
    assign in_entry.init_flags = in_tdata[193:192];
    assign in_entry.last       = in_tlast;

    assign in_tready  = (cnt_reg != 2'd2);
    assign push       = in_tvalid && in_tready;
    assign head.valid = (cnt_reg != 2'd0);
    assign head.entry = q_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= in_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, do_pop};
        end
    end

endmodule

/* rtl/core/smrk_back.sv */
// Back end: entry store, scan-based sort and merge, result register.
module smrk_back
    import smrk_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  queue_head_t           head,
    output logic                  pop,
    input  logic [1:0]            replicas_in_use,
    input  logic                  initiator_mode,
    output logic                  out_tvalid,
    input  logic                  out_tready,
    output logic [OUT_DATA_W-1:0] out_tdata,
    output logic                  out_tlast
);

    localparam int CW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [KEY_W-1:0]        kh_mem [CAPACITY];
    logic [KEY_W-1:0]        kl_mem [CAPACITY];
    logic [AMP_W-1:0]        a0_mem [CAPACITY];
    logic [AMP_W-1:0]        a1_mem [CAPACITY];
    logic [FLAG_W-1:0]       fl_mem [CAPACITY];

    logic [2*KEY_W-1:0]      rd_key_reg;
    logic signed [AMP_W-1:0] rd_a0_reg;
    logic signed [AMP_W-1:0] rd_a1_reg;
    logic [FLAG_W-1:0]       rd_fl_reg;
    logic                    rvalid_reg;

    logic [1:0]              state_reg;
    logic [NW-1:0]           count_reg;
    logic [NW-1:0]           scan_idx_reg;
    logic                    have_cur_reg;
    logic [2*KEY_W-1:0]      cur_reg;
    logic                    cand_v_reg;
    logic [2*KEY_W-1:0]      cand_reg;
    logic                    acc_v_reg;
    logic signed [AMP_W-1:0] acc0_reg;
    logic signed [AMP_W-1:0] acc1_reg;
    logic [FLAG_W-1:0]       fl_reg;
    logic [TOT_W-1:0]        tot0_reg;
    logic [TOT_W-1:0]        tot1_reg;
    logic                    ovf_reg;

    logic                    o_valid_reg;
    logic [2*KEY_W-1:0]      o_key_reg;
    logic [AMP_W-1:0]        o_a0_reg;
    logic [AMP_W-1:0]        o_a1_reg;
    logic [FLAG_W-1:0]       o_fl_reg;
    logic [TOT_W-1:0]        o_t0_reg;
    logic [TOT_W-1:0]        o_t1_reg;
    logic                    o_ovf_reg;
    logic                    o_last_reg;

    logic                    two_reps;
    logic                    full;
    logic                    issue;
    logic                    pass_done;
    logic                    out_free;
    logic                    key_eq;
    logic                    key_gt;
    logic                    key_lt_cand;

    assign two_reps    = (REPLICAS > 1) && (replicas_in_use >= 2'd2);
    assign full        = (count_reg == NW'(CAPACITY));
    assign pop         = (state_reg == ST_LOAD) && head.valid;
    assign issue       = (state_reg == ST_SCAN) && (scan_idx_reg < count_reg);
    assign pass_done   = (state_reg == ST_SCAN) && !issue && !rvalid_reg;
    assign out_free    = !o_valid_reg || out_tready;
    assign key_eq      = have_cur_reg && (rd_key_reg == cur_reg);
    // before the first key is found every entry is a candidate
    assign key_gt      = !have_cur_reg || (rd_key_reg > cur_reg);
    assign key_lt_cand = !cand_v_reg || (rd_key_reg < cand_reg);

    always_ff @(posedge clk)
    begin
        if (pop && !full)
        begin
            kh_mem[count_reg[CW-1:0]] <= head.entry.key_high;
            kl_mem[count_reg[CW-1:0]] <= head.entry.key_low;
            a0_mem[count_reg[CW-1:0]] <= head.entry.amp_first;
            a1_mem[count_reg[CW-1:0]] <= head.entry.amp_second;
            fl_mem[count_reg[CW-1:0]] <= head.entry.init_flags;
        end
        if (issue)
        begin
            rd_key_reg <= {kh_mem[scan_idx_reg[CW-1:0]], kl_mem[scan_idx_reg[CW-1:0]]};
            rd_a0_reg  <= a0_mem[scan_idx_reg[CW-1:0]];
            rd_a1_reg  <= a1_mem[scan_idx_reg[CW-1:0]];
            rd_fl_reg  <= fl_mem[scan_idx_reg[CW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rvalid_reg   <= 1'b0;
            have_cur_reg <= 1'b0;
            cand_v_reg   <= 1'b0;
            acc_v_reg    <= 1'b0;
            tot0_reg     <= '0;
            tot1_reg     <= '0;
            ovf_reg      <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            rvalid_reg <= issue;
            // in the emit state the result register is handled below
            if (o_valid_reg && out_tready && (state_reg != ST_EMIT))
                o_valid_reg <= 1'b0;
            case (state_reg)
                ST_LOAD:
                begin
                    if (pop)
                    begin
                        if (full)
                            ovf_reg <= 1'b1;
                        else
                            count_reg <= count_reg + 1'b1;
                        if (head.entry.last)
                        begin
                            state_reg    <= ST_SCAN;
                            scan_idx_reg <= '0;
                            have_cur_reg <= 1'b0;
                            cand_v_reg   <= 1'b0;
                            acc_v_reg    <= 1'b0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (issue)
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    if (rvalid_reg)
                    begin
                        if (key_eq)
                        begin
                            if (!acc_v_reg)
                            begin
                                acc_v_reg <= 1'b1;
                                acc0_reg  <= rd_a0_reg;
                                acc1_reg  <= rd_a1_reg;
                                fl_reg    <= rd_fl_reg;
                            end
                            else
                            begin
                                tot0_reg <= annihilate(tot0_reg, acc0_reg, rd_a0_reg);
                                acc0_reg <= sat_add(acc0_reg, rd_a0_reg);
                                if (two_reps)
                                begin
                                    tot1_reg <= annihilate(tot1_reg, acc1_reg, rd_a1_reg);
                                    acc1_reg <= sat_add(acc1_reg, rd_a1_reg);
                                end
                                fl_reg <= fl_reg | rd_fl_reg;
                            end
                        end
                        else if (key_gt && key_lt_cand)
                        begin
                            cand_v_reg <= 1'b1;
                            cand_reg   <= rd_key_reg;
                        end
                    end
                    if (pass_done)
                    begin
                        if (!have_cur_reg)
                        begin
                            have_cur_reg <= 1'b1;
                            cur_reg      <= cand_reg;
                            cand_v_reg   <= 1'b0;
                            scan_idx_reg <= '0;
                        end
                        else
                            state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        o_valid_reg <= 1'b1;
                        o_key_reg   <= cur_reg;
                        o_a0_reg    <= acc0_reg;
                        o_a1_reg    <= two_reps ? acc1_reg : '0;
                        o_fl_reg    <= initiator_mode ? fl_reg : '0;
                        o_last_reg  <= !cand_v_reg;
                        o_t0_reg    <= cand_v_reg ? '0 : tot0_reg;
                        o_t1_reg    <= (cand_v_reg || !two_reps) ? '0 : tot1_reg;
                        o_ovf_reg   <= !cand_v_reg && ovf_reg;
                        acc_v_reg   <= 1'b0;
                        if (cand_v_reg)
                        begin
                            cur_reg      <= cand_reg;
                            cand_v_reg   <= 1'b0;
                            scan_idx_reg <= '0;
                            state_reg    <= ST_SCAN;
                        end
                        else
                        begin
                            count_reg    <= '0;
                            tot0_reg     <= '0;
                            tot1_reg     <= '0;
                            ovf_reg      <= 1'b0;
                            have_cur_reg <= 1'b0;
                            state_reg    <= ST_LOAD;
                        end
                    end
                end
                default:
                    state_reg <= ST_LOAD;
            endcase
        end
    end

    assign out_tvalid = o_valid_reg;
    assign out_tlast  = o_last_reg;
    assign out_tdata  = {5'b0, o_ovf_reg, o_t1_reg, o_t0_reg, o_fl_reg, o_a1_reg, o_a0_reg,
                         o_key_reg[KEY_W-1:0], o_key_reg[2*KEY_W-1:KEY_W]};

endmodule

/* rtl/core/sort_merge_signed_reduce_by_key.sv */
// Top level of the sort-and-reduce-by-key block.
// Entries are taken one per cycle into a two-deep queue and written to a single-port
// store of CAPACITY entries. After the entry with tlast the back end sorts and merges by
// repeated scans of the store: one scan finds the smallest key, then one scan per distinct
// key merges its duplicates (in arrival order) while finding the next key. Each merged
// result is registered for output, and a stalled result holds the back end in its emit
// state. Input stalls during the scans and emits once the queue is full. The last merged
// result of a batch carries the annihilation totals and the overflow bit. The store needs
// no clearing after reset.
module sort_merge_signed_reduce_by_key
    import smrk_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // key_high, key_low, amp_first, amp_second, init_flags, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_key_high, out_key_low, out_amp_first, out_amp_second, out_flags,
    // annihil_first, annihil_second, overflow, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    queue_head_t head;
    logic        pop;
    logic [1:0]  replicas_reg;
    logic        init_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replicas_reg  <= 2'd1;
            init_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REPLICAS:  replicas_reg  <= cfg_data[1:0];
                CFG_INIT_MODE: init_mode_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    smrk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .in_tdata  (s_axis_tdata),
        .in_tlast  (s_axis_tlast),
        .head      (head),
        .pop       (pop)
    );

    smrk_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .pop             (pop),
        .replicas_in_use (replicas_reg),
        .initiator_mode  (init_mode_reg),
        .out_tvalid      (m_axis_tvalid),
        .out_tready      (m_axis_tready),
        .out_tdata       (m_axis_tdata),
        .out_tlast       (m_axis_tlast)
    );

endmodule

/* rtl/core/smrk_checker.sv */
// Port-level checks for the sort-and-reduce-by-key block, bound to the top level.
module smrk_checker
    import smrk_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    logic [2*KEY_W-1:0] key;
    assign key = {m_axis_tdata[O_KL-1:O_KH], m_axis_tdata[O_A0-1:O_KL]};

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // totals and overflow only on the final result of a batch
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[O_OVF:O_T0] == '0)
        else $error("batch totals on a non-final result");

    // keys strictly ascend between back-to-back results of a batch
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !m_axis_tvalid || (key > $past(key)))
        else $error("merged keys out of order");

endmodule

bind sort_merge_signed_reduce_by_key smrk_checker u_smrk_checker (.*);

/* verif/testbench.sv */
// Self-checking testbench for the sort and reduce-by-key block.
`timescale 1ns / 100ps

module testbench;
    import smrk_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 60;

    typedef struct {
        logic [63:0]        kh;
        logic [63:0]        kl;
        logic signed [31:0] a0;
        logic signed [31:0] a1;
        logic [1:0]         fl;
        logic [39:0]        t0;
        logic [39:0]        t1;
        logic               ovf;
        logic               last;
    } merged_t;

    typedef struct {
        logic [63:0]        kh;
        logic [63:0]        kl;
        logic signed [31:0] a0;
        logic signed [31:0] a1;
        logic [1:0]         fl;
        logic               last;
        logic               typed;  // expected result given in the row
        logic signed [31:0] exp_a0;
        logic signed [31:0] exp_a1;
        logic [1:0]         exp_fl;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // batch being collected by the predictor
    logic [63:0]        batch_kh[CAPACITY_DEF];
    logic [63:0]        batch_kl[CAPACITY_DEF];
    logic signed [31:0] batch_a0[CAPACITY_DEF];
    logic signed [31:0] batch_a1[CAPACITY_DEF];
    logic [1:0]         batch_fl[CAPACITY_DEF];
    int                 batch_count;
    logic               batch_dropped;
    logic [1:0]         replicas_reg;
    logic               init_mode_reg;

    merged_t   merged_q[$];
    int        errors;
    int        quiet_cycles;
    logic      no_idle;
    stim_row_t dir_rows[8];

    sort_merge_signed_reduce_by_key dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sd2147483647)
            return 32'sh7fffffff;
        if (s < -64'sd2147483648)
            return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic logic [39:0] cancel_total(logic [39:0] tot, logic signed [31:0] acc,
                                                 logic signed [31:0] x);
        longint ma;
        longint mx;
        longint s;
        if (!((acc < 0 && x > 0) || (acc > 0 && x < 0)))
            return tot;
        ma = (acc < 0) ? -longint'(acc) : longint'(acc);
        mx = (x < 0) ? -longint'(x) : longint'(x);
        s  = longint'(tot) + 2 * ((ma < mx) ? ma : mx);
        if (s > 64'h00ff_ffff_ffff)
            s = 64'h00ff_ffff_ffff;
        return s[39:0];
    endfunction

    function automatic logic key_above(int a, int b);
        if (batch_kh[a] != batch_kh[b])
            return batch_kh[a] > batch_kh[b];
        return batch_kl[a] > batch_kl[b];
    endfunction

    // sort the collected batch (stable), merge equal keys, queue the merged entries
    task automatic merge_batch();
        int          order[CAPACITY_DEF];
        int          i;
        int          j;
        int          head;
        int          reps;
        logic [39:0] tot0;
        logic [39:0] tot1;
        merged_t     m;
        reps = (replicas_reg < 1) ? 1 : (replicas_reg > 2) ? 2 : replicas_reg;
        tot0 = '0;
        tot1 = '0;
        for (i = 0; i < batch_count; i++)
        begin
            j = i;
            while (j > 0 && key_above(order[j-1], i))
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        i = 0;
        while (i < batch_count)
        begin
            head = order[i];
            m.kh = batch_kh[head];
            m.kl = batch_kl[head];
            m.a0 = batch_a0[head];
            m.a1 = batch_a1[head];
            m.fl = batch_fl[head];
            i++;
            while (i < batch_count && batch_kh[order[i]] == m.kh && batch_kl[order[i]] == m.kl)
            begin
                tot0 = cancel_total(tot0, m.a0, batch_a0[order[i]]);
                m.a0 = sat_sum(m.a0, batch_a0[order[i]]);
                if (reps > 1)
                begin
                    tot1 = cancel_total(tot1, m.a1, batch_a1[order[i]]);
                    m.a1 = sat_sum(m.a1, batch_a1[order[i]]);
                end
                m.fl |= batch_fl[order[i]];
                i++;
            end
            if (reps < 2)
                m.a1 = '0;
            if (!init_mode_reg)
                m.fl = '0;
            m.last = (i >= batch_count);
            m.t0   = m.last ? tot0 : '0;
            m.t1   = (m.last && reps > 1) ? tot1 : '0;
            m.ovf  = m.last ? batch_dropped : 1'b0;
            merged_q.push_back(m);
        end
        batch_count   = 0;
        batch_dropped = 1'b0;
    endtask

    task automatic absorb_entry(stim_row_t r);
        if (batch_count < CAPACITY_DEF)
        begin
            batch_kh[batch_count] = r.kh;
            batch_kl[batch_count] = r.kl;
            batch_a0[batch_count] = r.a0;
            batch_a1[batch_count] = r.a1;
            batch_fl[batch_count] = r.fl;
            batch_count++;
        end
        else
        begin
            batch_dropped = 1'b1;
        end
        if (r.last)
            merge_batch();
    endtask

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_entry(stim_row_t r);
        merged_t m;
        if (!no_idle && $urandom_range(0, 99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, r.fl, r.a1, r.a0, r.kl, r.kh};
        s_axis_tlast  <= r.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (r.typed)
        begin
            m.kh = r.kh;
            m.kl = r.kl;
            m.a0 = r.exp_a0;
            m.a1 = r.exp_a1;
            m.fl = r.exp_fl;
            m.t0 = '0;
            m.t1 = '0;
            m.ovf = 1'b0;
            m.last = 1'b1;
            merged_q.push_back(m);
        end
        else
        begin
            absorb_entry(r);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (merged_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_REPLICAS)
            replicas_reg = val;
        else
            init_mode_reg = val[0];
    endtask

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {$urandom, $urandom};
            default: return 64'(($urandom_range(0, 3)));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_amp();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_row_t random_entry(logic last);
        stim_row_t r;
        r.kh = pick_key();
        r.kl = pick_key();
        r.a0 = pick_amp();
        r.a1 = pick_amp();
        r.fl = 2'($urandom_range(0, 3));
        r.last = last;
        r.typed = 1'b0;
        r.exp_a0 = '0;
        r.exp_a1 = '0;
        r.exp_fl = '0;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        merged_t m;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (merged_q.size() == 0)
            begin
                $error("unexpected transaction: key %h_%h", m_axis_tdata[O_KH +: 64],
                       m_axis_tdata[O_KL +: 64]);
                errors++;
            end
            else
            begin
                m = merged_q.pop_front();
                check_field("out_key_high", m.kh, m_axis_tdata[O_KH +: 64]);
                check_field("out_key_low", m.kl, m_axis_tdata[O_KL +: 64]);
                check_field("out_amp_first", 64'($unsigned(m.a0)),
                            64'(m_axis_tdata[O_A0 +: 32]));
                check_field("out_amp_second", 64'($unsigned(m.a1)),
                            64'(m_axis_tdata[O_A1 +: 32]));
                check_field("out_flags", 64'(m.fl), 64'(m_axis_tdata[O_FL +: 2]));
                check_field("annihil_first", 64'(m.t0), 64'(m_axis_tdata[O_T0 +: 40]));
                check_field("annihil_second", 64'(m.t1), 64'(m_axis_tdata[O_T1 +: 40]));
                check_field("overflow", 64'(m.ovf), 64'(m_axis_tdata[O_OVF]));
                check_field("out_last", 64'(m.last), 64'(m_axis_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 25);
    end

    // watchdog: cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [1:0] phase_reps[6];
        logic       phase_init[6];
        int         p;
        int         k;
        int         n;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_REPLICAS;
        cfg_data = '0;
        errors = 0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        batch_count = 0;
        batch_dropped = 1'b0;
        replicas_reg = 2'd1;
        init_mode_reg = 1'b0;
        phase_reps = '{2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1};
        phase_init = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

        // kh, kl, a0, a1, fl, last, typed, exp_a0, exp_a1, exp_fl
        dir_rows[0] = '{'1, '1, 32'sh7fffffff, 32'sh80000000, 2'd3, 1'b1, 1'b1,
                        32'sh7fffffff, 32'sh80000000, 2'd3};
        dir_rows[1] = '{'0, '0, 32'sh0, 32'sh0, 2'd0, 1'b1, 1'b1, 32'sh0, 32'sh0, 2'd0};
        // duplicates saturating, opposite signs cancelling, out-of-order keys
        dir_rows[2] = '{64'd5, 64'd1, 32'sh7fffffff, 32'sh80000000, 2'd1, 1'b0, 1'b0,
                        '0, '0, '0};
        dir_rows[3] = '{64'd5, 64'd1, 32'sh7fffffff, 32'sh80000000, 2'd0, 1'b0, 1'b0,
                        '0, '0, '0};
        dir_rows[4] = '{64'd5, 64'd0, 32'sh80000000, 32'sh7fffffff, 2'd2, 1'b0, 1'b0,
                        '0, '0, '0};
        dir_rows[5] = '{64'd5, 64'd0, 32'sh00000001, 32'shffffffff, 2'd1, 1'b0, 1'b0,
                        '0, '0, '0};
        dir_rows[6] = '{64'd0, '1, -32'sd5, 32'sd3, 2'd0, 1'b0, 1'b0, '0, '0, '0};
        dir_rows[7] = '{64'd5, 64'd1, 32'sh80000000, 32'sh7fffffff, 2'd2, 1'b1, 1'b0,
                        '0, '0, '0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_REPLICAS, 2'd2);
        write_reg(CFG_INIT_MODE, 2'd1);
        foreach (dir_rows[i])
            send_entry(dir_rows[i]);
        drain_results();

        for (p = 0; p < 6; p++)
        begin
            write_reg(CFG_REPLICAS, phase_reps[p]);
            write_reg(CFG_INIT_MODE, {1'b0, phase_init[p]});
            no_idle = (p == 1);
            k = 0;
            while (k < 30)
            begin
                n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
                for (int e = 0; e < n; e++)
                    send_entry(random_entry(e == n - 1));
                k += n;
            end
            // one batch larger than the store
            if (p == 4)
            begin
                for (int e = 0; e < CAPACITY_DEF + 4; e++)
                    send_entry(random_entry(e == CAPACITY_DEF + 3));
            end
            drain_results();
        end
        no_idle = 1'b0;

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* files.f */
rtl/core/smrk_pkg.sv
rtl/core/smrk_front.sv
rtl/core/smrk_back.sv
rtl/core/sort_merge_signed_reduce_by_key.sv
rtl/core/smrk_checker.sv
verif/testbench.sv
